### hdl/tdw_pkg.sv
// ----------------------------------------------------------------------------
// tdw_pkg: shared types and constants of the tick delay wait table
// Holds the table size, field widths, command and reply codes, and the
// packed layout of one stored waiter entry.
// ----------------------------------------------------------------------------
package tdw_pkg;

  // table size and identifier width kept per waiter
  localparam int MAX_WAITERS = 16;
  localparam int ID_BITS     = 8;

  // fixed field widths of the channels
  localparam int CMD_W   = 2;
  localparam int REQ_W   = 8;
  localparam int TICK_W  = 32;
  localparam int KIND_W  = 3;

  // table index and fill count widths
  localparam int IDX_W = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
  localparam int CNT_W = $clog2(MAX_WAITERS + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_TIME  = 2'd0,
    CMD_DELAY = 2'd1,
    CMD_ABS   = 2'd2,
    CMD_TICK  = 2'd3
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_TIME  = 3'd0,
    KIND_DELAY = 3'd1,
    KIND_ABS   = 3'd2,
    KIND_TICK  = 3'd3,
    KIND_FULL  = 3'd4
  } kind_t;

  // one parked waiter
  typedef struct packed {
    logic [ID_BITS-1:0] id;
    logic [TICK_W-1:0]  target;
    logic               is_abs;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // keep the low ID_BITS of a requester field
  function automatic logic [ID_BITS-1:0] to_id(input logic [REQ_W-1:0] req);
    logic [ID_BITS+REQ_W-1:0] wide;
    wide = {{ID_BITS{1'b0}}, req};
    return wide[ID_BITS-1:0];
  endfunction

  // widen or cut a stored identifier to the reply field
  function automatic logic [REQ_W-1:0] to_req(input logic [ID_BITS-1:0] id);
    logic [REQ_W+ID_BITS-1:0] wide;
    wide = {{REQ_W{1'b0}}, id};
    return wide[REQ_W-1:0];
  endfunction

endpackage

### hdl/tdw_ifs.sv
// ----------------------------------------------------------------------------
// tdw_ifs: request and reply channels of the tick delay wait table
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface tdw_req_if;
  logic                        valid;
  logic                        ready;
  logic [tdw_pkg::CMD_W-1:0]   command;
  logic [tdw_pkg::REQ_W-1:0]   requester;
  logic [tdw_pkg::TICK_W-1:0]  tick_amount;

  modport source (output valid, command, requester, tick_amount, input ready);
  modport sink   (input valid, command, requester, tick_amount, output ready);
endinterface

interface tdw_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [tdw_pkg::KIND_W-1:0]  reply_kind;
  logic [tdw_pkg::REQ_W-1:0]   reply_to;
  logic [tdw_pkg::TICK_W-1:0]  current_ticks;
  logic                        last;

  modport source (output valid, reply_kind, reply_to, current_ticks, last, input ready);
  modport sink   (input valid, reply_kind, reply_to, current_ticks, last, output ready);
endinterface

### hdl/tdw_ram.sv
// ----------------------------------------------------------------------------
// tdw_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module tdw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/tick_delay_wait_table.sv
// ----------------------------------------------------------------------------
// tick_delay_wait_table: tick counter with a table of parked requesters
// Keeps a wrapping 32-bit tick count and releases delayed requesters in
// arrival order once their target tick is reached.
// ----------------------------------------------------------------------------
// A time query, a relative delay or an absolute delay needs no scan;
// a query or a table-full reject leaves one reply beat in the output
// register. A tick is accepted, then every parked waiter is checked as the
// table RAM is read one entry a cycle, unless a release waits on a stalled
// reply channel, and compacted in place, and then the final beat is
// emitted. The tick acknowledge comes first, then each release in
// arrival order, and the final beat carries last. Requests are taken only
// when the block is idle and the output register is free.
module tick_delay_wait_table (
  input  logic       clk,
  input  logic       rst,
  tdw_req_if.sink    req,
  tdw_rsp_if.source  rsp
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t                        state;
  logic [tdw_pkg::TICK_W-1:0]    tick_count;
  logic [tdw_pkg::CNT_W-1:0]     waiter_count;
  logic [tdw_pkg::CNT_W-1:0]     scan_idx;
  logic [tdw_pkg::CNT_W-1:0]     keep_idx;
  tdw_pkg::kind_t                pend_kind;
  logic [tdw_pkg::ID_BITS-1:0]   pend_id;

  logic                          out_valid;
  tdw_pkg::kind_t                out_kind;
  logic [tdw_pkg::REQ_W-1:0]     out_to;
  logic [tdw_pkg::TICK_W-1:0]    out_ticks;
  logic                          out_last;

  logic                          out_free;
  logic                          accept;
  tdw_pkg::cmd_t                 cmd;
  logic [tdw_pkg::ID_BITS-1:0]   who;
  logic                          full;
  logic                          at_end;
  logic                          hit;
  logic                          advance;
  logic                          finish;
  logic [tdw_pkg::CNT_W-1:0]     scan_idx_next;

  logic                          ram_we;
  logic [tdw_pkg::IDX_W-1:0]     ram_waddr;
  tdw_pkg::entry_t               ram_wdata;
  logic [tdw_pkg::IDX_W-1:0]     ram_raddr;
  tdw_pkg::entry_t               ram_rdata;
  logic [tdw_pkg::ENTRY_W-1:0]   ram_rbits;

  // decode the request and scan conditions
  assign out_free      = !out_valid || rsp.ready;
  assign req.ready     = (state == ST_IDLE) && out_free;
  assign accept        = req.valid && req.ready;
  assign cmd           = tdw_pkg::cmd_t'(req.command);
  assign who           = tdw_pkg::to_id(req.requester);
  assign full          = waiter_count == tdw_pkg::CNT_W'(tdw_pkg::MAX_WAITERS);
  assign ram_rdata     = tdw_pkg::entry_t'(ram_rbits);
  assign at_end        = scan_idx == waiter_count;
  assign hit           = ram_rdata.target <= tick_count;
  assign advance       = (state == ST_SCAN) && !at_end && (!hit || out_free);
  assign finish        = (state == ST_SCAN) && at_end && out_free;
  assign scan_idx_next = scan_idx + tdw_pkg::CNT_W'(1);

  // pick the read address: entry 0 ahead of a scan, else the next entry when advancing or the entry on view
  always_comb begin
    if (state == ST_SCAN) begin
      ram_raddr = advance ? scan_idx_next[tdw_pkg::IDX_W-1:0]
                          : scan_idx[tdw_pkg::IDX_W-1:0];
    end else begin
      ram_raddr = '0;
    end
  end

  // append a new waiter, or write back a kept one during the scan
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = waiter_count[tdw_pkg::IDX_W-1:0];
    ram_wdata = ram_rdata;
    if (state == ST_SCAN) begin
      ram_we    = advance && !hit;
      ram_waddr = keep_idx[tdw_pkg::IDX_W-1:0];
      ram_wdata = ram_rdata;
    end else if (accept && (cmd == tdw_pkg::CMD_DELAY || cmd == tdw_pkg::CMD_ABS)) begin
      ram_we           = !full;
      ram_wdata.id     = who;
      ram_wdata.target = (cmd == tdw_pkg::CMD_DELAY) ? req.tick_amount + tick_count
                                                     : req.tick_amount;
      ram_wdata.is_abs = cmd == tdw_pkg::CMD_ABS;
    end
  end

  tdw_ram #(
    .WIDTH (tdw_pkg::ENTRY_W),
    .DEPTH (tdw_pkg::MAX_WAITERS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rbits)
  );

  // control: sequence commands and the release scan
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      tick_count   <= '0;
      waiter_count <= '0;
      scan_idx     <= '0;
      keep_idx     <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (cmd)
              tdw_pkg::CMD_TIME: begin
              end
              tdw_pkg::CMD_DELAY, tdw_pkg::CMD_ABS: begin
                if (!full) begin
                  waiter_count <= waiter_count + tdw_pkg::CNT_W'(1);
                end
              end
              tdw_pkg::CMD_TICK: begin
                tick_count <= tick_count + tdw_pkg::TICK_W'(1);
                scan_idx   <= '0;
                keep_idx   <= '0;
                state      <= ST_SCAN;
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (advance) begin
            scan_idx <= scan_idx_next;
            if (!hit) begin
              keep_idx <= keep_idx + tdw_pkg::CNT_W'(1);
            end
          end
          if (finish) begin
            waiter_count <= keep_idx;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // hold the newest reply of a tick until the next one shows whether it is last
  always_ff @(posedge clk) begin
    if (accept && cmd == tdw_pkg::CMD_TICK) begin
      pend_kind <= tdw_pkg::KIND_TICK;
      pend_id   <= who;
    end else if (advance && hit) begin
      pend_kind <= ram_rdata.is_abs ? tdw_pkg::KIND_ABS : tdw_pkg::KIND_DELAY;
      pend_id   <= ram_rdata.id;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((accept && (cmd == tdw_pkg::CMD_TIME || full) && cmd != tdw_pkg::CMD_TICK)
                 || (advance && hit) || finish) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (accept && cmd == tdw_pkg::CMD_TIME) begin
      out_kind  <= tdw_pkg::KIND_TIME;
      out_to    <= tdw_pkg::to_req(who);
      out_ticks <= tick_count;
      out_last  <= 1'b1;
    end else if (accept && cmd != tdw_pkg::CMD_TICK && full) begin
      out_kind  <= tdw_pkg::KIND_FULL;
      out_to    <= tdw_pkg::to_req(who);
      out_ticks <= tick_count;
      out_last  <= 1'b1;
    end else if ((advance && hit) || finish) begin
      out_kind  <= pend_kind;
      out_to    <= tdw_pkg::to_req(pend_id);
      out_ticks <= tick_count;
      out_last  <= finish;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.reply_kind    = out_kind;
  assign rsp.reply_to      = out_to;
  assign rsp.current_ticks = out_ticks;
  assign rsp.last          = out_last;

endmodule
